>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Transaction types, command and status codes, the control group shared by the
// controller and the datapath, and the datapath status group.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_POP    = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key_prio;
    logic        [31:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_prio;
    logic        [31:0] payload_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

>>> rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// A row of sorted cells, each comparing its priority with the request key in
// parallel and shifting to make room on insert or to close the gap on pop.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::ctrl_cmd_t ctrl,
  input  spq_pkg::in_item_t  in_item,
  output spq_pkg::out_item_t out_item,
  output spq_pkg::dp_stat_t  stat
);

  localparam int CW = $clog2(CAPACITY + 1);

  spq_pkg::in_item_t  req_r;
  spq_pkg::out_item_t out_r;
  spq_pkg::out_item_t out_nxt;
  logic signed [31:0] prio_r [CAPACITY];
  logic        [31:0] pay_r  [CAPACITY];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CAPACITY-1:0] lt;
  logic               is_full;
  logic               is_empty;
  logic               ins_ok;
  logic               pop_ok;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign ins_ok   = ctrl.exec && (req_r.cmd == spq_pkg::CMD_INSERT) && !is_full;
  assign pop_ok   = ctrl.exec && (req_r.cmd == spq_pkg::CMD_POP) && !is_empty;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_r <= in_item;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    assign lt[i] = (IDX < count_r) && ($signed(prio_r[i]) < $signed(req_r.key_prio));

    always_ff @(posedge clk) begin
      if (ins_ok && !lt[i]) begin
        if (i == 0) begin
          prio_r[i] <= req_r.key_prio;
          pay_r[i]  <= req_r.payload_in;
        end else if (lt[(i == 0) ? 0 : i - 1]) begin
          prio_r[i] <= req_r.key_prio;
          pay_r[i]  <= req_r.payload_in;
        end else begin
          prio_r[i] <= prio_r[(i == 0) ? 0 : i - 1];
          pay_r[i]  <= pay_r[(i == 0) ? 0 : i - 1];
        end
      end else if (pop_ok && (i < CAPACITY - 1)) begin
        prio_r[i] <= prio_r[(i < CAPACITY - 1) ? i + 1 : i];
        pay_r[i]  <= pay_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    out_nxt.status      = spq_pkg::ST_OK;
    out_nxt.out_prio    = '0;
    out_nxt.payload_out = '0;
    if (req_r.cmd == spq_pkg::CMD_INSERT) begin
      if (is_full) begin
        out_nxt.status = spq_pkg::ST_FULL;
      end
    end else if (is_empty) begin
      out_nxt.status = spq_pkg::ST_EMPTY;
    end else begin
      out_nxt.out_prio    = prio_r[0];
      out_nxt.payload_out = pay_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_item   = out_r;
  assign stat.full  = is_full;
  assign stat.empty = is_empty;

endmodule

>>> rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences each transaction through a request capture cycle and an execute
// cycle, and owns the handshake on both channels.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::ctrl_cmd_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign ctrl.load = (state_r == S_IDLE) && in_valid;
  assign ctrl.exec = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Each transaction is captured, then executed once the output is free; the
// next one is not taken until it has executed. The execute step compares the
// key against every cell in parallel and shifts the whole row at once.
// A stalled result holds the execute cycle of the following transaction.
// Reset clears the fill count and the handshake state; cell contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Min-priority queue kept in ascending order in a row of shifting cells.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_item
);

  spq_pkg::ctrl_cmd_t ctrl;
  spq_pkg::dp_stat_t  stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_item  (in_item),
    .out_item (out_item),
    .stat     (stat)
  );

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue reports full and empty at once");

  a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> in_stall)
    else $error("input not stalled after a transaction was taken");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |=> out_valid)
    else $error("execute cycle did not produce a result");

  a_load_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.load && ctrl.exec))
    else $error("capture and execute in the same cycle");

endmodule
